// File: src/grsc_pkg.sv
// Package for the gamma ramp sample converter: formats, register indexes and payload types.
package grsc_pkg;

  typedef enum logic [2:0] {
    FMT_U16 = 3'd0,
    FMT_U32 = 3'd1,
    FMT_U64 = 3'd2,
    FMT_F32 = 3'd3,
    FMT_F64 = 3'd4
  } fmt_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_SOURCE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET = 2'd1;

  typedef struct packed {
    logic [63:0] sample_in;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] sample_out;
    logic        last_out;
  } out_item_t;

  // Normalized value after leading-one alignment.
  typedef struct packed {
    logic [63:0] norm;
    logic [63:0] aligned;
    logic [5:0]  lz;
  } align_t;

endpackage

// File: src/grsc_decode.sv
// Decoder from a source sample format to the normalized 64-bit scale.
module grsc_decode (
  input  logic [2:0]  src_fmt_i,
  input  logic [63:0] raw_i,
  output logic [63:0] norm_o
);
  import grsc_pkg::*;

  logic        s32, s64, pos32, pos64;
  logic [7:0]  e32;
  logic [10:0] e64;
  logic [23:0] m24;
  logic [52:0] m53;
  logic [63:0] v32, v64;

  always_comb begin
    s32   = raw_i[31];
    e32   = raw_i[30:23];
    m24   = {e32 != 8'd0, raw_i[22:0]};
    pos32 = !s32 && !(e32 == 8'd0 && raw_i[22:0] == 23'd0) &&
            !(e32 == 8'hFF && raw_i[22:0] != 23'd0);
    if (!pos32) begin
      v32 = '0;
    end else if (e32 >= 8'd127) begin
      v32 = '1;
    end else if (e32 >= 8'd86) begin
      v32 = {40'd0, m24} << (e32 - 8'd86);
    end else begin
      v32 = {40'd0, m24} >> (8'd86 - e32);
    end

    s64   = raw_i[63];
    e64   = raw_i[62:52];
    m53   = {e64 != 11'd0, raw_i[51:0]};
    pos64 = !s64 && !(e64 == 11'd0 && raw_i[51:0] == 52'd0) &&
            !(e64 == 11'h7FF && raw_i[51:0] != 52'd0);
    if (!pos64) begin
      v64 = '0;
    end else if (e64 >= 11'd1023) begin
      v64 = '1;
    end else if (e64 >= 11'd1011) begin
      v64 = {11'd0, m53} << (e64 - 11'd1011);
    end else begin
      v64 = {11'd0, m53} >> (11'd1011 - e64);
    end

    unique case (src_fmt_i)
      FMT_U16: norm_o = {4{raw_i[15:0]}};
      FMT_U32: norm_o = {2{raw_i[31:0]}};
      FMT_U64: norm_o = raw_i;
      FMT_F32: norm_o = v32;
      FMT_F64: norm_o = v64;
      default: norm_o = '0;
    endcase
  end

endmodule

// File: src/grsc_align.sv
// Leading-one search that shifts the normalized value up to bit 63.
module grsc_align (
  input  logic [63:0]      norm_i,
  output grsc_pkg::align_t align_o
);
  import grsc_pkg::*;

  logic [63:0] w;
  logic [5:0]  lz;

  // Six halving steps give the shift count and the shifted word together.
  always_comb begin
    w  = norm_i;
    lz = '0;
    if (w[63:32] == 32'd0) begin
      w     = w << 32;
      lz[5] = 1'b1;
    end
    if (w[63:48] == 16'd0) begin
      w     = w << 16;
      lz[4] = 1'b1;
    end
    if (w[63:56] == 8'd0) begin
      w     = w << 8;
      lz[3] = 1'b1;
    end
    if (w[63:60] == 4'd0) begin
      w     = w << 4;
      lz[2] = 1'b1;
    end
    if (w[63:62] == 2'd0) begin
      w     = w << 2;
      lz[1] = 1'b1;
    end
    if (w[63] == 1'b0) begin
      w     = w << 1;
      lz[0] = 1'b1;
    end
    align_o.norm    = norm_i;
    align_o.aligned = w;
    align_o.lz      = lz;
  end

endmodule

// File: src/grsc_encode.sv
// Encoder from the aligned normalized value to the target sample format.
module grsc_encode (
  input  logic [2:0]       tgt_fmt_i,
  input  grsc_pkg::align_t align_i,
  output logic [63:0]      sample_o
);
  import grsc_pkg::*;

  logic        rnd32, rnd64;
  logic [31:0] f32;
  logic [62:0] f64;
  logic [7:0]  ex32;
  logic [10:0] ex64;
  logic [63:0] n;

  always_comb begin
    n     = align_i.aligned;
    // The implicit one in the significand lifts the exponent by one; a rounding
    // carry out of the significand lifts it once more.
    ex32  = 8'd125 - {2'd0, align_i.lz};
    rnd32 = n[39] && ((n[38:0] != '0) || n[40]);
    f32   = {1'b0, ex32, 23'd0} + {8'd0, n[63:40]} + {31'd0, rnd32};
    ex64  = 11'd1021 - {5'd0, align_i.lz};
    rnd64 = n[10] && ((n[9:0] != '0) || n[11]);
    f64   = {ex64, 52'd0} + {10'd0, n[63:11]} + {62'd0, rnd64};

    unique case (tgt_fmt_i)
      FMT_U16: sample_o = {48'd0, align_i.norm[63:48] | {15'd0, align_i.norm[47]}};
      FMT_U32: sample_o = {32'd0, align_i.norm[63:32] | {31'd0, align_i.norm[31]}};
      FMT_U64: sample_o = align_i.norm;
      FMT_F32: sample_o = (align_i.norm == '0) ? '0 : {32'd0, f32};
      FMT_F64: sample_o = (align_i.norm == '0) ? '0 : {1'b0, f64};
      default: sample_o = '0;
    endcase
  end

endmodule

// File: src/gamma_ramp_sample_converter.sv
// Top level of the gamma ramp sample converter: three-stage pipeline and config registers.
//
// Use: samples arrive on the in channel (in_valid_i/in_ready_o, in_data_i) and
// leave on the out channel (out_valid_o/out_ready_i, out_data_o), one result per
// sample, in order. The source and target formats are set through the config
// channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i), index 0 for the
// source and 1 for the target; the port always takes a transfer, and writes
// should land while no sample is in flight.
// Stage one decodes to the normalized scale, stage two runs the leading-one
// shift, stage three rounds and packs into the output register.
// Throughput is one sample per cycle while the receiver takes results. When
// the receiver stalls, each stage holds its item and bubbles close up; input
// is refused only once all three stages are full.
// Reset clears the valid bits of all stages and sets both formats to the
// 16-bit integer code.
module gamma_ramp_sample_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [grsc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [grsc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  grsc_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output grsc_pkg::out_item_t               out_data_o
);
  import grsc_pkg::*;

  logic [2:0]  src_fmt_q, tgt_fmt_q;
  logic        s1_v_q, s2_v_q, s3_v_q;
  logic        s1_en, s2_en, s3_en;
  logic [63:0] s1_norm_q, s1_norm_d;
  logic [2:0]  s1_tgt_q, s2_tgt_q;
  logic        s1_last_q, s2_last_q;
  align_t      s2_align_q, s2_align_d;
  out_item_t   s3_q, s3_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FMT_U16;
      tgt_fmt_q <= FMT_U16;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_SOURCE) src_fmt_q <= cfg_data_i[2:0];
      if (cfg_index_i == REG_TARGET) tgt_fmt_q <= cfg_data_i[2:0];
    end
  end

  assign s3_en      = !s3_v_q || out_ready_i;
  assign s2_en      = !s2_v_q || s3_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_ready_o = s1_en;

  grsc_decode u_decode (
    .src_fmt_i(src_fmt_q),
    .raw_i    (in_data_i.sample_in),
    .norm_o   (s1_norm_d)
  );

  grsc_align u_align (
    .norm_i (s1_norm_q),
    .align_o(s2_align_d)
  );

  grsc_encode u_encode (
    .tgt_fmt_i(s2_tgt_q),
    .align_i  (s2_align_q),
    .sample_o (s3_d.sample_out)
  );
  assign s3_d.last_out = s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_en) s1_v_q <= in_valid_i;
      if (s2_en) s2_v_q <= s1_v_q;
      if (s3_en) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_norm_q <= s1_norm_d;
      s1_tgt_q  <= tgt_fmt_q;
      s1_last_q <= in_data_i.last_in;
    end
    if (s2_en) begin
      s2_align_q <= s2_align_d;
      s2_tgt_q   <= s1_tgt_q;
      s2_last_q  <= s1_last_q;
    end
    if (s3_en) s3_q <= s3_d;
  end

  assign out_valid_o = s3_v_q;
  assign out_data_o  = s3_q;

  // A held middle stage keeps its item while the output stage is blocked.
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !s2_en |=> s2_v_q && $stable(s2_align_q) && $stable(s2_last_q))
    else $error("middle stage lost or changed a held item");

  // Input is refused only when every stage holds an item.
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_v_q && s2_v_q && s3_v_q && !out_ready_i)
    else $error("input refused with room in the pipeline");

  // A transfer into a stalled first stage cannot happen.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s2_en |=> s1_v_q && $stable(s1_norm_q))
    else $error("first stage overwritten while stalled");

endmodule

// File: tb/testbench.sv
// Testbench for the gamma ramp sample converter: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import grsc_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_data_o;

  gamma_ramp_sample_converter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  logic [2:0]  src_fmt_q;
  logic [2:0]  dst_fmt_q;
  out_item_t   pending_results[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          recv_hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Float bits to the normalized scale: scale by 2^64, truncate, saturate at one.
  function automatic logic [63:0] float_to_norm(logic [63:0] bits, int ebits, int fbits);
    logic        sign;
    int          expo;
    int          bias;
    int          sh;
    logic [63:0] frac;
    logic [63:0] full;
    sign = bits[ebits + fbits];
    expo = int'((bits >> fbits) & ((64'd1 << ebits) - 1));
    frac = bits & ((64'd1 << fbits) - 1);
    bias = (1 << (ebits - 1)) - 1;
    if (expo == (1 << ebits) - 1) begin
      if (frac != 0 || sign) return 64'd0;
      return '1;
    end
    if (sign || (expo == 0 && frac == 0)) return 64'd0;
    if (expo >= bias) return '1;
    full = (expo == 0) ? frac : ((64'd1 << fbits) | frac);
    sh = ((expo == 0) ? 1 : expo) - bias + 64 - fbits;
    if (sh >= 0) return full << sh;
    if (-sh >= 64) return 64'd0;
    return full >> (-sh);
  endfunction

  // Normalized value divided by 2^64 as float bits, rounded to nearest even.
  function automatic logic [63:0] norm_to_float(logic [63:0] x, int mbits, int bias);
    int          p;
    int          sh;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] biased;
    if (x == 0) return 64'd0;
    p = 63;
    while (!x[p]) p--;
    if (p + 1 <= mbits) begin
      mant = x << (mbits - 1 - p);
    end else begin
      sh = p + 1 - mbits;
      rem = x & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      mant = x >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << mbits)) begin
        mant = mant >> 1;
        p++;
      end
    end
    biased = 64'(bias + p - 64);
    return (biased << (mbits - 1)) | (mant & ((64'd1 << (mbits - 1)) - 1));
  endfunction

  function automatic logic [63:0] convert_sample(logic [63:0] raw);
    logic [63:0] norm;
    logic [63:0] t;
    case (src_fmt_q)
      FMT_U16: norm = {4{raw[15:0]}};
      FMT_U32: norm = {2{raw[31:0]}};
      FMT_U64: norm = raw;
      FMT_F32: norm = float_to_norm({32'd0, raw[31:0]}, 8, 23);
      FMT_F64: norm = float_to_norm(raw, 11, 52);
      default: norm = 64'd0;
    endcase
    case (dst_fmt_q)
      FMT_U16: begin
        t = norm >> 47;
        return 64'((t[0] | t[16:1]) & 16'hFFFF) & 64'hFFFF;
      end
      FMT_U32: begin
        t = norm >> 31;
        return {32'd0, t[32:1] | {31'd0, t[0]}};
      end
      FMT_U64: return norm;
      FMT_F32: return norm_to_float(norm, 24, 127);
      FMT_F64: return norm_to_float(norm, 53, 1023);
      default: return 64'd0;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h (src %0d dst %0d) at %0t",
             what, got, want, src_fmt_q, dst_fmt_q, $realtime);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_data_o.sample_out, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.sample_out !== want.sample_out)
          report("sample", out_data_o.sample_out, want.sample_out);
        if (out_data_o.last_out !== want.last_out)
          report("last flag", 64'(out_data_o.last_out), 64'(want.last_out));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted down on request.
  always @(negedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(logic [63:0] sample, logic last);
    out_item_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{sample_in: sample, last_in: last};
    do @(posedge clk_i); while (!in_ready_o);
    want.sample_out = convert_sample(sample);
    want.last_out = last;
    pending_results.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SOURCE) src_fmt_q = data[2:0];
    else if (idx == REG_TARGET) dst_fmt_q = data[2:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_formats(logic [2:0] src, logic [2:0] dst);
    write_reg(REG_SOURCE, {5'($urandom), src});
    write_reg(REG_TARGET, {5'($urandom), dst});
  endtask

  function automatic logic [63:0] random_sample(logic [2:0] fmt);
    logic [63:0] v;
    int          pick;
    v = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (fmt == FMT_F32 && pick < 75) begin
      v[31] = ($urandom_range(9) == 0);
      v[30:23] = (pick < 10) ? 8'($urandom_range(126)) : 8'($urandom_range(126, 100));
    end else if (fmt == FMT_F64 && pick < 75) begin
      v[63] = ($urandom_range(9) == 0);
      v[62:52] = (pick < 10) ? 11'($urandom_range(1022)) : 11'($urandom_range(1022, 960));
    end
    return v;
  endfunction

  task automatic test_integer_paths();
    set_formats(FMT_U16, FMT_U64);
    send_sample(64'hFFFF_FFFF_FFFF_0000, 1'b0);
    send_sample(64'h0000_0000_0000_FFFF, 1'b1);
    send_sample(64'hDEAD_BEEF_0000_8001, 1'b0);
    set_formats(FMT_U64, FMT_U16);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_sample(64'h0000_8000_0000_0000, 1'b0);
    send_sample(64'h1234_7FFF_FFFF_FFFF, 1'b0);
    set_formats(FMT_U32, FMT_U32);
    send_sample(64'hFFFF_FFFF_0000_0000, 1'b1);
    send_sample(64'h0000_0000_8000_0001, 1'b0);
  endtask

  task automatic test_float_special();
    set_formats(FMT_F32, FMT_F64);
    send_sample(64'h0000_0000_3F80_0000, 1'b0);  // exactly one
    send_sample(64'hFFFF_FFFF_7F80_0000, 1'b1);  // +infinity
    send_sample(64'h0000_0000_7FC0_0000, 1'b0);  // NaN
    send_sample(64'h0000_0000_BF00_0000, 1'b0);  // negative
    send_sample(64'h0000_0000_0000_0001, 1'b0);  // smallest subnormal
    send_sample(64'h0000_0000_3F7F_FFFF, 1'b1);
    set_formats(FMT_F64, FMT_F32);
    send_sample(64'h3FEF_FFFF_FFFF_FFFF, 1'b0);  // rounds up to one in single
    send_sample(64'h8000_0000_0000_0000, 1'b1);  // negative zero
    send_sample(64'h3FE0_0000_0000_0001, 1'b0);
    set_formats(FMT_U64, FMT_F32);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'h0000_0000_0000_0001, 1'b1);
    set_formats(3'd5, 3'd7);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    set_formats(FMT_U16, 3'd6);
    send_sample(64'h0000_0000_0000_ABCD, 1'b0);
    // Writes to unused indexes must leave the formats alone.
    write_reg(2'd2, 8'hFF);
    write_reg(2'd3, 8'h04);
    send_sample(64'h0000_0000_0000_1234, 1'b1);
  endtask

  task automatic test_random_formats();
    int phase;
    phase = 0;
    for (int s = 0; s < 8; s++) begin
      for (int d = 0; d < 8; d++) begin
        if ((s > 4 || d > 4) && !(s == 7 && d == 7) && !(s == 2 && d == 5)) continue;
        set_formats(3'(s), 3'(d));
        case (phase % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
          default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
        phase++;
        for (int n = 0; n < 30; n++) send_sample(random_sample(3'(s)), 1'($urandom));
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_formats(FMT_F64, FMT_U32);
    recv_hold_cycles = 60;
    for (int n = 0; n < 40; n++) send_sample(random_sample(FMT_F64), 1'($urandom));
  endtask

  initial begin
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold_cycles = 0;
    src_fmt_q = FMT_U16;
    dst_fmt_q = FMT_U16;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_sample(64'h0000_0000_0000_FFFF, 1'b1);  // reset formats
    test_integer_paths();
    test_float_special();
    test_random_formats();
    test_backpressure();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
src/grsc_pkg.sv
src/grsc_decode.sv
src/grsc_align.sv
src/grsc_encode.sv
src/gamma_ramp_sample_converter.sv
tb/testbench.sv
